/* hw/rtl/slc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slc_pkg: shared constants for the scalar literal classifier
// Kind codes, character codes and the special-literal spelling table.
// ----------------------------------------------------------------------------
package slc_pkg;

  localparam int unsigned KindW = 3;
  localparam int unsigned NumSpecial = 6;
  localparam int unsigned IntMaxLen = 12;

  localparam logic [KindW-1:0] KIND_CHAR    = 3'd0;
  localparam logic [KindW-1:0] KIND_INT     = 3'd1;
  localparam logic [KindW-1:0] KIND_FLOAT   = 3'd2;
  localparam logic [KindW-1:0] KIND_DOUBLE  = 3'd3;
  localparam logic [KindW-1:0] KIND_SPECIAL = 3'd4;
  localparam logic [KindW-1:0] KIND_INVALID = 3'd5;

  localparam logic [7:0] CH_QUOTE = 8'h27;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UC_E  = 8'h45;
  localparam logic [7:0] CH_UC_F  = 8'h46;
  localparam logic [7:0] CH_LC_E  = 8'h65;
  localparam logic [7:0] CH_LC_F  = 8'h66;
  localparam logic [7:0] CH_LC_I  = 8'h69;
  localparam logic [7:0] CH_LC_N  = 8'h6E;
  localparam logic [7:0] CH_LC_A  = 8'h61;

  // nan, nanf, +inf, -inf, +inff, -inff
  localparam logic [2:0] SPECIAL_LEN [NumSpecial] = '{3'd3, 3'd4, 3'd4, 3'd4, 3'd5, 3'd5};

  // spelling of special literal k at position p (p below 5)
  function automatic logic [7:0] special_char(input logic [2:0] k, input logic [2:0] p);
    logic [7:0] ch;
    ch = 8'h00;
    case (k)
      3'd0, 3'd1: begin
        case (p)
          3'd0:    ch = CH_LC_N;
          3'd1:    ch = CH_LC_A;
          3'd2:    ch = CH_LC_N;
          3'd3:    ch = CH_LC_F;
          default: ch = 8'h00;
        endcase
      end
      default: begin
        case (p)
          3'd0:    ch = (k == 3'd2 || k == 3'd4) ? CH_PLUS : CH_MINUS;
          3'd1:    ch = CH_LC_I;
          3'd2:    ch = CH_LC_N;
          3'd3:    ch = CH_LC_F;
          3'd4:    ch = CH_LC_F;
          default: ch = 8'h00;
        endcase
      end
    endcase
    return ch;
  endfunction

endpackage

/* hw/rtl/slc_track.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slc_track: per-token tracking state and verdict logic
// Updates the token flags for one request and forms the kind on the last one.
// ----------------------------------------------------------------------------
module slc_track
  import slc_pkg::*;
#(
  parameter int unsigned MaxLen = 255
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [7:0]       char_code_i,
  input  logic             last_char_i,
  output logic [KindW-1:0] kind_o
);

  localparam int unsigned CntW = $clog2(MaxLen + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MaxLen);

  typedef struct packed {
    logic dead;
    logic pend;
    logic dig;
    logic exp;
    logic dot;
  } scan_t;

  typedef struct packed {
    logic f;
    logic exp;
    logic dot;
  } seen_t;

  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [7:0]            first_q, first_d;
  logic                  tq_q, tq_d;
  logic [NumSpecial-1:0] pm_q, pm_d;
  seen_t                 seen_q, seen_d;
  logic                  ido_q, ido_d;
  scan_t                 scan_q, scan_d;

  logic c_digit, c_sign, c_dot, c_e, c_f, pos0, scan_ok, special;
  scan_t s1;

  assign c_digit = (char_code_i >= CH_ZERO) && (char_code_i <= CH_NINE);
  assign c_sign  = (char_code_i == CH_PLUS) || (char_code_i == CH_MINUS);
  assign c_dot   = (char_code_i == CH_DOT);
  assign c_e     = (char_code_i == CH_LC_E) || (char_code_i == CH_UC_E);
  assign c_f     = (char_code_i == CH_LC_F) || (char_code_i == CH_UC_F);
  assign pos0    = (cnt_q == '0);

  always_comb begin
    first_d = pos0 ? char_code_i : first_q;
    tq_d    = tq_q | ((cnt_q == CntW'(2)) && (char_code_i == CH_QUOTE));
    for (int k = 0; k < NumSpecial; k++) begin
      pm_d[k] = pm_q[k] && (cnt_q < CntW'(SPECIAL_LEN[k]))
              && (special_char(3'(k), cnt_q[2:0]) == char_code_i);
    end
    seen_d.dot = seen_q.dot | c_dot;
    seen_d.exp = seen_q.exp | c_e;
    seen_d.f   = seen_q.f | c_f;
    ido_d      = ido_q & (c_digit | (pos0 & c_sign));
    cnt_d      = (cnt_q < CntMax) ? cnt_q + CntW'(1) : cnt_q;

    s1      = scan_q;
    s1.pend = 1'b0;
    scan_d  = scan_q;
    if (!scan_q.dead) begin
      if ((scan_q.pend || pos0) && c_sign) begin
        scan_d = s1;
      end else if (c_digit) begin
        scan_d     = s1;
        scan_d.dig = 1'b1;
      end else if (c_dot && !s1.dot && !s1.exp) begin
        scan_d     = s1;
        scan_d.dot = 1'b1;
      end else if (c_e && !s1.exp && s1.dig) begin
        scan_d      = s1;
        scan_d.exp  = 1'b1;
        scan_d.pend = 1'b1;
        scan_d.dig  = 1'b0;
      end else if (c_f && last_char_i) begin
        scan_d = s1;
      end else begin
        scan_d      = s1;
        scan_d.dead = 1'b1;
      end
    end
  end

  always_comb begin
    special = 1'b0;
    for (int k = 0; k < NumSpecial; k++) begin
      if (pm_d[k] && (cnt_d == CntW'(SPECIAL_LEN[k]))) begin
        special = 1'b1;
      end
    end
    scan_ok = !scan_d.dead && scan_d.dig;
    kind_o  = KIND_INVALID;
    if (special) begin
      kind_o = KIND_SPECIAL;
    end else if (seen_d == '0) begin
      if (((cnt_d == CntW'(1)) && !((first_d >= CH_ZERO) && (first_d <= CH_NINE))) ||
          ((cnt_d == CntW'(3)) && (first_d == CH_QUOTE) && tq_d)) begin
        kind_o = KIND_CHAR;
      end else if (ido_d && (cnt_d < CntW'(IntMaxLen))) begin
        kind_o = KIND_INT;
      end
    end else if (seen_d.f) begin
      if (scan_ok) kind_o = KIND_FLOAT;
    end else begin
      if (scan_ok) kind_o = KIND_DOUBLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      first_q <= '0;
      tq_q    <= 1'b0;
      pm_q    <= '1;
      seen_q  <= '0;
      ido_q   <= 1'b1;
      scan_q  <= '0;
    end else if (step_i) begin
      if (last_char_i) begin
        cnt_q   <= '0;
        first_q <= '0;
        tq_q    <= 1'b0;
        pm_q    <= '1;
        seen_q  <= '0;
        ido_q   <= 1'b1;
        scan_q  <= '0;
      end else begin
        cnt_q   <= cnt_d;
        first_q <= first_d;
        tq_q    <= tq_d;
        pm_q    <= pm_d;
        seen_q  <= seen_d;
        ido_q   <= ido_d;
        scan_q  <= scan_d;
      end
    end
  end

endmodule

/* hw/rtl/scalar_literal_classifier.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scalar_literal_classifier: numeric literal lexer
// Classifies a token streamed one character per request.
//
//   channel | signals                                   | direction
//   in      | in_valid_i, in_stall_o, char_code_i,      | request in
//           | last_char_i                               |
//   out     | out_valid_o, out_stall_i, literal_kind_o  | request out
//
// One character per cycle unless the output stalls; a kind leaves through the
// input register, then the result register, after the last character is taken.
// Reset clears the token state and both valid flags. A stall on a valid output
// freezes both stages and is passed back to in_stall_o in the same cycle.
// ----------------------------------------------------------------------------
module scalar_literal_classifier
  import slc_pkg::*;
#(
  parameter int unsigned MAX_LEN = 255
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [7:0]       char_code_i,
  input  logic             last_char_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [KindW-1:0] literal_kind_o
);

  logic             adv;
  logic             iv_q;
  logic [7:0]       ch_q;
  logic             last_q;
  logic             ov_q;
  logic [KindW-1:0] kind_q;
  logic [KindW-1:0] kind_d;

  assign adv        = !(ov_q && out_stall_i);
  assign in_stall_o = !adv;

  slc_track #(
    .MaxLen (MAX_LEN)
  ) u_track (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (adv && iv_q),
    .char_code_i (ch_q),
    .last_char_i (last_q),
    .kind_o      (kind_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iv_q <= 1'b0;
      ov_q <= 1'b0;
    end else if (adv) begin
      iv_q <= in_valid_i;
      ov_q <= iv_q && last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ch_q   <= char_code_i;
      last_q <= last_char_i;
      kind_q <= kind_d;
    end
  end

  assign out_valid_o    = ov_q;
  assign literal_kind_o = kind_q;

endmodule

/* test/tb_scalar_literal_classifier.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_scalar_literal_classifier: self-checking bench for the literal lexer
// Streams tokens one character per request and checks each emitted kind
// against an in-bench lexer model or a pinned kind. A directed table covers
// the special literals, char forms, integer length limits and float/double
// shapes. A random token mix follows, run under several sender/receiver idle
// phases, with one long output hold-off and drains between phases.
// ----------------------------------------------------------------------------
module tb_scalar_literal_classifier;
  import slc_pkg::*;

  typedef logic [7:0] byte_q_t [$];

  typedef struct packed {
    logic             pinned;
    logic [KindW-1:0] kind;
  } kind_pin_t;

  typedef struct {
    string            text;
    logic [7:0]       raw;
    bit               pinned;
    logic [KindW-1:0] kind;
  } lex_case_t;

  localparam int HoldCycles = 60;
  localparam int PhaseChars = 150;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  logic [7:0]       char_code_i = 8'h00;
  logic             last_char_i = 1'b0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic [KindW-1:0] literal_kind_o;

  int idle_pct = 0;
  int stall_pct = 0;
  bit long_hold_req = 1'b0;
  int mismatch_count = 0;
  int phase_idle [4] = '{0, 61, 0, 27};
  int phase_stall [4] = '{0, 0, 61, 27};

  logic [KindW-1:0] kind_exp_q [$];
  kind_pin_t        typed_kind_q [$];

  string special_text [6] = '{"nan", "nanf", "+inf", "-inf", "+inff", "-inff"};
  string lex_alpha = "0123456789+-.eEfF'nai";

  lex_case_t directed_cases [25] = '{
    '{"", 8'h00, 1'b1, KIND_CHAR},
    '{"", 8'hFF, 1'b1, KIND_CHAR},
    '{"a", 8'h00, 1'b1, KIND_CHAR},
    '{"0", 8'h00, 1'b1, KIND_INT},
    '{"'x'", 8'h00, 1'b1, KIND_CHAR},
    '{"'.'", 8'h00, 1'b0, KIND_INVALID},
    '{"nan", 8'h00, 1'b1, KIND_SPECIAL},
    '{"nanf", 8'h00, 1'b1, KIND_SPECIAL},
    '{"+inf", 8'h00, 1'b1, KIND_SPECIAL},
    '{"-inf", 8'h00, 1'b1, KIND_SPECIAL},
    '{"+inff", 8'h00, 1'b1, KIND_SPECIAL},
    '{"-inff", 8'h00, 1'b1, KIND_SPECIAL},
    '{"nanff", 8'h00, 1'b0, KIND_INVALID},
    '{"+1234567890", 8'h00, 1'b1, KIND_INT},
    '{"-12345678901", 8'h00, 1'b1, KIND_INVALID},
    '{"3.14f", 8'h00, 1'b0, KIND_INVALID},
    '{"1e10", 8'h00, 1'b0, KIND_INVALID},
    '{"-2.5E-3", 8'h00, 1'b0, KIND_INVALID},
    '{"1.5e+7F", 8'h00, 1'b0, KIND_INVALID},
    '{".5", 8'h00, 1'b0, KIND_INVALID},
    '{"1e", 8'h00, 1'b0, KIND_INVALID},
    '{"1.2.3", 8'h00, 1'b0, KIND_INVALID},
    '{"e5", 8'h00, 1'b0, KIND_INVALID},
    '{"f", 8'h00, 1'b0, KIND_INVALID},
    '{"12f3", 8'h00, 1'b0, KIND_INVALID}
  };

  // lexer model state
  logic [7:0] lex_len;
  logic [7:0] lex_first;
  logic       lex_third_quote;
  logic [5:0] lex_special;
  logic       lex_seen_dot, lex_seen_exp, lex_seen_f;
  logic       lex_int_ok;
  logic       sc_dot, sc_exp, sc_dig, sc_pend, sc_dead;

  scalar_literal_classifier i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .char_code_i   (char_code_i),
    .last_char_i   (last_char_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .literal_kind_o(literal_kind_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic bit is_dig(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic bit is_sgn(input logic [7:0] c);
    return c == CH_PLUS || c == CH_MINUS;
  endfunction

  function automatic bit is_exp_ch(input logic [7:0] c);
    return c == CH_LC_E || c == CH_UC_E;
  endfunction

  function automatic bit is_f_ch(input logic [7:0] c);
    return c == CH_LC_F || c == CH_UC_F;
  endfunction

  function automatic void lex_clear();
    lex_len = 8'd0;
    lex_first = 8'd0;
    lex_third_quote = 1'b0;
    lex_special = 6'h3F;
    lex_seen_dot = 1'b0;
    lex_seen_exp = 1'b0;
    lex_seen_f = 1'b0;
    lex_int_ok = 1'b1;
    {sc_dot, sc_exp, sc_dig, sc_pend, sc_dead} = '0;
  endfunction

  function automatic void lex_step(input logic [7:0] c, input logic last,
                                   output logic done, output logic [KindW-1:0] kind);
    logic [7:0] pos;
    logic       skip;
    logic       scan_ok;
    pos = lex_len;
    if (pos == 8'd0) lex_first = c;
    if (pos == 8'd2 && c == CH_QUOTE) lex_third_quote = 1'b1;
    for (int k = 0; k < 6; k++) begin
      if (pos >= special_text[k].len() || special_text[k][pos] != c) lex_special[k] = 1'b0;
    end
    if (c == CH_DOT) lex_seen_dot = 1'b1;
    if (is_exp_ch(c)) lex_seen_exp = 1'b1;
    if (is_f_ch(c)) lex_seen_f = 1'b1;
    if (!is_dig(c) && !(pos == 8'd0 && is_sgn(c))) lex_int_ok = 1'b0;

    if (!sc_dead) begin
      skip = 1'b0;
      if (sc_pend) begin
        sc_pend = 1'b0;
        if (is_sgn(c)) skip = 1'b1;
      end
      if (!skip && pos == 8'd0 && is_sgn(c)) skip = 1'b1;
      if (!skip) begin
        if (is_dig(c)) begin
          sc_dig = 1'b1;
        end else if (c == CH_DOT && !sc_dot && !sc_exp) begin
          sc_dot = 1'b1;
        end else if (is_exp_ch(c) && !sc_exp && sc_dig) begin
          sc_exp = 1'b1;
          sc_pend = 1'b1;
          sc_dig = 1'b0;
        end else if (is_f_ch(c) && last) begin
          // suffix keeps the digit flag as is
        end else begin
          sc_dead = 1'b1;
        end
      end
    end

    if (lex_len != 8'd255) lex_len = lex_len + 8'd1;

    done = last;
    kind = KIND_INVALID;
    if (last) begin
      for (int k = 0; k < 6; k++) begin
        if (lex_special[k] && lex_len == special_text[k].len()) kind = KIND_SPECIAL;
      end
      if (kind != KIND_SPECIAL) begin
        scan_ok = !sc_dead && sc_dig;
        if (!lex_seen_dot && !lex_seen_exp && !lex_seen_f) begin
          if ((lex_len == 8'd1 && !is_dig(lex_first)) ||
              (lex_len == 8'd3 && lex_first == CH_QUOTE && lex_third_quote))
            kind = KIND_CHAR;
          else if (lex_int_ok && lex_len < IntMaxLen)
            kind = KIND_INT;
        end else if (lex_seen_f) begin
          if (scan_ok) kind = KIND_FLOAT;
        end else begin
          if (scan_ok) kind = KIND_DOUBLE;
        end
      end
      lex_clear();
    end
  endfunction

  // scoreboard: result side first, request side second
  always @(posedge clk_i) begin : scoreboard
    logic [KindW-1:0] want;
    logic [KindW-1:0] model_kind;
    logic             done;
    kind_pin_t        pin;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (kind_exp_q.size() == 0) begin
          $error("literal_kind: no result expected, got %0d", literal_kind_o);
          mismatch_count++;
        end else begin
          want = kind_exp_q.pop_front();
          if (literal_kind_o !== want) begin
            $error("literal_kind: expected %0d, got %0d", want, literal_kind_o);
            mismatch_count++;
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        lex_step(char_code_i, last_char_i, done, model_kind);
        if (done) begin
          pin = typed_kind_q.pop_front();
          kind_exp_q.push_back(pin.pinned ? pin.kind : model_kind);
        end
      end
    end
  end

  initial begin : receiver
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
      end
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send_char(input logic [7:0] c, input logic last);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      char_code_i <= 8'($urandom);
      last_char_i <= 1'($urandom);
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    char_code_i <= c;
    last_char_i <= last;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
  endtask

  task automatic send_token(input byte_q_t tok, input kind_pin_t pin);
    typed_kind_q.push_back(pin);
    foreach (tok[i]) send_char(tok[i], i == tok.size() - 1);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (kind_exp_q.size() != 0 || typed_kind_q.size() != 0);
  endtask

  function automatic logic [7:0] rand_sign();
    return $urandom_range(1) ? CH_PLUS : CH_MINUS;
  endfunction

  function automatic byte_q_t rand_digits(input int n);
    byte_q_t d;
    repeat (n) d.push_back(CH_ZERO + 8'($urandom_range(9)));
    return d;
  endfunction

  function automatic byte_q_t make_number(input bit with_suffix);
    byte_q_t t;
    if ($urandom_range(2) == 0) t.push_back(rand_sign());
    t = {t, rand_digits($urandom_range(0, 4))};
    if ($urandom_range(1)) begin
      t.push_back(CH_DOT);
      t = {t, rand_digits($urandom_range(0, 4))};
    end
    if ($urandom_range(1)) begin
      t.push_back($urandom_range(1) ? CH_LC_E : CH_UC_E);
      if ($urandom_range(1)) t.push_back(rand_sign());
      t = {t, rand_digits($urandom_range(0, 3))};
    end
    if (with_suffix) t.push_back($urandom_range(1) ? CH_LC_F : CH_UC_F);
    if (t.size() == 0) t.push_back(CH_ZERO);
    return t;
  endfunction

  function automatic byte_q_t make_token();
    byte_q_t t;
    int      k;
    int      pos;
    case ($urandom_range(9))
      0, 1: begin
        if ($urandom_range(1)) t.push_back(rand_sign());
        t = {t, rand_digits(($urandom_range(3) == 0) ? $urandom_range(9, 14)
                                                     : $urandom_range(1, 8))};
      end
      2, 3: t = make_number(1'b0);
      4, 5: t = make_number(1'b1);
      6: begin
        k = $urandom_range(5);
        for (int i = 0; i < special_text[k].len(); i++) t.push_back(special_text[k][i]);
        case ($urandom_range(3))
          0: begin
            pos = $urandom_range(t.size() - 1);
            t[pos] = lex_alpha[$urandom_range(lex_alpha.len() - 1)];
          end
          1: void'(t.pop_back());
          2: t.push_back(CH_LC_F);
          default: begin
          end
        endcase
      end
      7: begin
        if ($urandom_range(1)) begin
          t.push_back(8'($urandom_range(255)));
        end else begin
          t.push_back(CH_QUOTE);
          t.push_back(8'($urandom_range(255)));
          t.push_back(CH_QUOTE);
        end
      end
      8: repeat ($urandom_range(1, 8)) t.push_back(8'($urandom_range(255)));
      default: begin
        t = make_number(1'($urandom_range(1)));
        pos = $urandom_range(t.size() - 1);
        t[pos] = lex_alpha[$urandom_range(lex_alpha.len() - 1)];
      end
    endcase
    return t;
  endfunction

  initial begin : stimulus
    byte_q_t tok;
    int      sent_chars;
    lex_clear();
    sent_chars = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_cases[r]) begin
      tok.delete();
      if (directed_cases[r].text.len() == 0) begin
        tok.push_back(directed_cases[r].raw);
      end else begin
        for (int i = 0; i < directed_cases[r].text.len(); i++)
          tok.push_back(directed_cases[r].text[i]);
      end
      send_token(tok, kind_pin_t'{directed_cases[r].pinned, directed_cases[r].kind});
    end

    // long double, length counter saturates
    tok = rand_digits(1);
    tok.push_back(CH_DOT);
    tok = {tok, rand_digits(256)};
    send_token(tok, kind_pin_t'{1'b1, KIND_DOUBLE});
    drain_results();

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = phase_idle[ph];
      stall_pct = phase_stall[ph];
      if (ph == 0) long_hold_req = 1'b1;
      while (sent_chars < (ph + 1) * PhaseChars) begin
        tok = make_token();
        send_token(tok, kind_pin_t'{1'b0, KIND_INVALID});
        sent_chars += tok.size();
      end
      drain_results();
    end

    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0)
      $display("tb_scalar_literal_classifier OK");
    else
      $display("tb_scalar_literal_classifier NOT OK");
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("tb_scalar_literal_classifier NOT OK");
    $finish;
  end

endmodule
